// ===== src/xml_text_normalizer_core_assert.svh =====
// ---------------------------------------------------------------------------
// XML text normalizer assertion macros
// Shared forms for the concurrent checks of the normalizer core.
// ---------------------------------------------------------------------------
`ifndef XML_TEXT_NORMALIZER_CORE_ASSERT_SVH
`define XML_TEXT_NORMALIZER_CORE_ASSERT_SVH

// Plain concurrent check, disabled while reset is asserted.
`define XTN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled request keeps its payload until it is taken.
`define XTN_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `XTN_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> (vld) && $stable(sig), msg)

`endif

// ===== src/xtn_pkg.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer package
// Widths, character codes, scan modes and shared structs.
// ---------------------------------------------------------------------------
package xtn_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned MAX_RES  = 4;
  localparam int unsigned RES_CW   = 3;   // holds 0..MAX_RES
  localparam int unsigned RES_IW   = 2;   // indexes 0..MAX_RES-1

  localparam logic [UNIT_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [UNIT_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_BANG  = 16'h0021;
  localparam logic [UNIT_W-1:0] CH_DASH  = 16'h002D;
  localparam logic [UNIT_W-1:0] CH_LT    = 16'h003C;
  localparam logic [UNIT_W-1:0] CH_GT    = 16'h003E;
  localparam logic [UNIT_W-1:0] TEXT_LIMIT = 16'd512;

  localparam logic [1:0] DASH_CLOSE = 2'd2;

  typedef enum logic [5:0] {
    MODE_TEXT    = 6'b000001,
    MODE_LT      = 6'b000010,
    MODE_LTB     = 6'b000100,
    MODE_LTBD    = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_TAG     = 6'b100000
  } xtn_mode_e;

  typedef struct packed {
    xtn_mode_e  mode;
    logic [1:0] dash_run;
    logic       space_run;
  } xtn_state_t;

  typedef struct packed {
    logic [RES_CW-1:0]              cnt;
    logic [MAX_RES-1:0][UNIT_W-1:0] units;
    logic [MAX_RES-1:0]             ends;
  } xtn_res_t;

  // Held units of a partial "<!-" opener, in order.
  function automatic logic [UNIT_W-1:0] prefix_unit(logic [RES_IW-1:0] idx);
    logic [UNIT_W-1:0] u;
    case (idx)
      2'd0:    u = CH_LT;
      2'd1:    u = CH_BANG;
      default: u = CH_DASH;
    endcase
    return u;
  endfunction

endpackage

// ===== src/xtn_if.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer channels
// Valid/ready interfaces for input units, results and configuration.
// ---------------------------------------------------------------------------
interface xtn_in_if;
  import xtn_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface xtn_out_if;
  import xtn_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] out_unit;
  logic              end_of_text;
  modport source (output valid, output out_unit, output end_of_text, input ready);
  modport sink   (input valid, input out_unit, input end_of_text, output ready);
endinterface

interface xtn_cfg_if;
  logic valid;
  logic ready;
  logic space_mode;
  modport source (output valid, output space_mode, input ready);
  modport sink   (input valid, input space_mode, output ready);
endinterface

// ===== src/xtn_step.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer step logic
// Next scan state and up to four results for one code unit.
// ---------------------------------------------------------------------------
module xtn_step (
  input  xtn_pkg::xtn_state_t         state_i,
  input  logic                        space_mode_i,
  input  logic [xtn_pkg::UNIT_W-1:0]  code_unit_i,
  output xtn_pkg::xtn_state_t         state_o,
  output xtn_pkg::xtn_res_t           res_o
);
  import xtn_pkg::*;

  logic              zero;
  logic              flush;
  logic [RES_IW-1:0] pfx;

  assign zero = (code_unit_i == CH_NUL);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    pfx     = '0;
    flush   = zero;

    case (state_i.mode)
      MODE_LT: begin
        pfx = 2'd1;
        if (code_unit_i == CH_BANG) begin
          state_o.mode = MODE_LTB;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_LTB: begin
        pfx = 2'd2;
        if (code_unit_i == CH_DASH) begin
          state_o.mode = MODE_LTBD;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_LTBD: begin
        pfx = 2'd3;
        if (code_unit_i == CH_DASH) begin
          state_o.mode     = MODE_COMMENT;
          state_o.dash_run = '0;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (code_unit_i == CH_DASH) begin
          if (state_i.dash_run < DASH_CLOSE) begin
            state_o.dash_run = state_i.dash_run + 2'd1;
          end
        end else if (code_unit_i == CH_GT && state_i.dash_run >= DASH_CLOSE) begin
          state_o.mode     = MODE_TEXT;
          state_o.dash_run = '0;
        end else begin
          state_o.dash_run = '0;
        end
      end
      MODE_TAG: begin
        res_o.cnt      = RES_CW'(1);
        res_o.units[0] = code_unit_i;
        state_o.mode   = (code_unit_i == CH_GT) ? MODE_TEXT : MODE_TAG;
      end
      default: begin
        // text
        state_o.mode = MODE_TEXT;
        if (code_unit_i == CH_LT) begin
          state_o.mode = MODE_LT;
        end else if (space_mode_i && code_unit_i == CH_SPACE) begin
          if (!state_i.space_run) begin
            res_o.cnt         = RES_CW'(1);
            res_o.units[0]    = CH_SPACE;
            state_o.space_run = 1'b1;
          end
        end else if ((code_unit_i > CH_SPACE && code_unit_i < TEXT_LIMIT) ||
                     code_unit_i == CH_SPACE) begin
          res_o.cnt         = RES_CW'(1);
          res_o.units[0]    = code_unit_i;
          state_o.space_run = 1'b0;
        end
      end
    endcase

    // held opener units, then the terminator or the first tag unit
    if (flush) begin
      res_o = '0;
      for (int i = 0; i < MAX_RES - 1; i++) begin
        if (RES_IW'(i) < pfx) begin
          res_o.units[i] = prefix_unit(RES_IW'(i));
        end
      end
      res_o.units[pfx] = zero ? CH_NUL : code_unit_i;
      res_o.ends[pfx]  = zero;
      res_o.cnt        = {1'b0, pfx} + RES_CW'(1);
      if (zero) begin
        state_o.mode      = MODE_TEXT;
        state_o.dash_run  = '0;
        state_o.space_run = 1'b0;
      end else begin
        state_o.mode = (code_unit_i == CH_GT) ? MODE_TEXT : MODE_TAG;
      end
    end
  end

endmodule

// ===== src/xtn_out_buf.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer result buffer
// Holds the results of one unit and hands them out one per request.
// ---------------------------------------------------------------------------
module xtn_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  xtn_pkg::xtn_res_t    res_i,
  output logic                 load_ok_o,
  xtn_out_if.source            out_if
);
  import xtn_pkg::*;

  logic [RES_CW-1:0]              cnt_q, cnt_d;
  logic [RES_CW-1:0]              rd_q, rd_d;
  logic [MAX_RES-1:0][UNIT_W-1:0] units_q;
  logic [MAX_RES-1:0]             ends_q;
  logic                           empty;
  logic                           take;
  logic                           last;

  assign empty     = (rd_q == cnt_q);
  assign take      = out_if.valid && out_if.ready;
  assign last      = ((rd_q + RES_CW'(1)) == cnt_q);
  assign load_ok_o = empty || (take && last);

  assign out_if.valid       = !empty;
  assign out_if.out_unit    = units_q[rd_q[RES_IW-1:0]];
  assign out_if.end_of_text = ends_q[rd_q[RES_IW-1:0]];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
      rd_d  = '0;
    end else if (take) begin
      rd_d = rd_q + RES_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      units_q <= res_i.units;
      ends_q  <= res_i.ends;
    end
  end

endmodule

// ===== src/xml_text_normalizer_core.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer core
// Drops comments, copies tags, filters text, collapses spaces in space_mode.
// ---------------------------------------------------------------------------
// channel  dir  payload                  note
// in_if    in   code_unit                zero ends the document
// out_if   out  out_unit, end_of_text    terminator carries end_of_text
// cfg_if   in   space_mode               always ready
//
// An accepted unit is held in the input register, then its results (zero
// to four) are loaded into the result buffer and sent one per cycle while
// out_if is ready. A unit with at most one result sustains one unit per
// cycle when out_if is ready; held opener units go out one at a time.
// Reset clears the scan state, space_mode and both buffers.
// ---------------------------------------------------------------------------
module xml_text_normalizer_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  xtn_in_if.sink   in_if,
  xtn_out_if.source out_if,
  xtn_cfg_if.sink  cfg_if
);
  import xtn_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic [UNIT_W-1:0] in_unit_q;
  logic              space_mode_q;
  xtn_state_t        st_q, st_d;
  xtn_state_t        st_next;
  xtn_res_t          res;
  logic              load_ok;
  logic              xfer;

  assign cfg_if.ready = 1'b1;
  assign xfer         = in_vld_q && load_ok;
  assign in_if.ready  = !in_vld_q || load_ok;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_if.valid && in_if.ready) begin
      in_vld_d = 1'b1;
    end else if (xfer) begin
      in_vld_d = 1'b0;
    end
    st_d = xfer ? st_next : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      space_mode_q <= 1'b0;
      st_q         <= '{mode: MODE_TEXT, dash_run: 2'd0, space_run: 1'b0};
    end else begin
      in_vld_q <= in_vld_d;
      st_q     <= st_d;
      if (cfg_if.valid) begin
        space_mode_q <= cfg_if.space_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_unit_q <= in_if.code_unit;
    end
  end

  xtn_step u_step (
    .state_i      (st_q),
    .space_mode_i (space_mode_q),
    .code_unit_i  (in_unit_q),
    .state_o      (st_next),
    .res_o        (res)
  );

  xtn_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (xfer),
    .res_i     (res),
    .load_ok_o (load_ok),
    .out_if    (out_if)
  );

endmodule

// ===== src/xtn_checker.sv =====
// ---------------------------------------------------------------------------
// XML text normalizer port checks
// Result and configuration rules seen at the core's ports.
// ---------------------------------------------------------------------------
`include "xml_text_normalizer_core_assert.svh"

module xtn_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [xtn_pkg::UNIT_W-1:0] out_unit_i,
  input logic                       end_of_text_i,
  input logic                       cfg_ready_i
);
  import xtn_pkg::*;

  `XTN_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, {out_unit_i, end_of_text_i}, "stalled result changed")
  `XTN_ASSERT(a_term_zero, clk_i, rst_ni, out_valid_i && end_of_text_i |-> out_unit_i == CH_NUL, "terminator unit not zero")
  `XTN_ASSERT(a_unit_nonzero, clk_i, rst_ni, out_valid_i && !end_of_text_i |-> out_unit_i != CH_NUL, "zero unit without end flag")
  `XTN_ASSERT(a_cfg_ready, clk_i, rst_ni, 1'b1 |-> cfg_ready_i, "config port not ready")

endmodule

bind xml_text_normalizer_core xtn_checker u_xtn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_unit_i    (out_if.out_unit),
  .end_of_text_i (out_if.end_of_text),
  .cfg_ready_i   (cfg_if.ready)
);
